>>> hdl/dssp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dssp_pkg
// Shared types and constants of the depth-ordering point sorter.
// ----------------------------------------------------------------------------
package dssp_pkg;

    localparam int KEY_BITS = 32;
    localparam int OUT_BITS = 32;

    typedef enum logic [7:0] {
        S_LOAD      = 8'b0000_0001,
        S_GAP       = 8'b0000_0010,
        S_READ      = 8'b0000_0100,
        S_CMP       = 8'b0000_1000,
        S_SWAP      = 8'b0001_0000,
        S_EMIT_RD   = 8'b0010_0000,
        S_EMIT_LD   = 8'b0100_0000,
        S_EMIT_WAIT = 8'b1000_0000
    } t_state;

endpackage

>>> hdl/dssp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dssp_ram
// Generic RAM with one write port and two read ports with registered data.
// ----------------------------------------------------------------------------
module dssp_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

>>> hdl/depth_shell_sort_points_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_shell_sort_points_top
// Collects a set of points, sorts them by signed depth key with a Shell sort
// using halving gaps, and emits them in ascending key order.
//
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  depth_key, x_coord, y_coord, final_point
// output    out        o_valid / i_stall  sorted_key, sorted_x, sorted_y,
//                                         end_of_set, overflowed
//
// During loading every valid item is taken. The sort is run by one shared compare
// unit over the dual-read point RAM: a compare step reads a pair, compares the
// keys and writes both entries back when the pair is exchanged; a gap step opens
// each pass and ends the sort. Emission presents each point until it is accepted.
// Reset is synchronous and clears only control state. No item is taken after the
// end of a set until its last result has been delivered.
// ----------------------------------------------------------------------------
module depth_shell_sort_points_top #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_depth_key,
    input  logic signed [31:0] i_x_coord,
    input  logic signed [31:0] i_y_coord,
    input  logic               i_final_point,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_sorted_key,
    output logic signed [31:0] o_sorted_x,
    output logic signed [31:0] o_sorted_y,
    output logic               o_end_of_set,
    output logic               o_overflowed
);

    import dssp_pkg::*;

    localparam int AW   = $clog2(MAX_POINTS);
    localparam int CNTW = $clog2(MAX_POINTS + 1);
    localparam int DW   = KEY_BITS + 2 * COORD_BITS;

    t_state          r_state, n_state;
    logic [CNTW-1:0] r_count, n_count;
    logic            r_ovf, n_ovf;
    logic [CNTW-1:0] r_gap, n_gap;
    logic [CNTW-1:0] r_i, n_i;
    logic [CNTW-1:0] r_j, n_j;
    logic            r_out_valid, n_out_valid;
    logic [DW-1:0]   r_lo;

    logic signed [OUT_BITS-1:0] r_out_key, r_out_x, r_out_y;
    logic                       r_out_end, r_out_ovf;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [DW-1:0]   ram_wdata;
    logic [AW-1:0]   ram_raddr_a, ram_raddr_b;
    logic [DW-1:0]   ram_rdata_a, ram_rdata_b;

    logic            in_accept;
    logic            out_accept;
    logic [CNTW-1:0] i_inc;
    logic [CNTW-1:0] k_idx;
    logic            keys_in_order;

    assign in_accept  = i_valid && (r_state == S_LOAD);
    assign out_accept = r_out_valid && !i_stall;
    assign i_inc      = r_i + CNTW'(1);
    assign k_idx      = r_j + r_gap;
    assign keys_in_order = $signed(ram_rdata_a[KEY_BITS-1:0])
                        <= $signed(ram_rdata_b[KEY_BITS-1:0]);

    dssp_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (ram_rdata_a),
        .o_rdata_b (ram_rdata_b)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_gap       = r_gap;
        n_i         = r_i;
        n_j         = r_j;
        n_out_valid = r_out_valid;
        ram_we      = 1'b0;
        ram_waddr   = r_j[AW-1:0];
        ram_wdata   = ram_rdata_b;
        ram_raddr_a = r_j[AW-1:0];
        ram_raddr_b = k_idx[AW-1:0];

        case (r_state)
            S_LOAD: begin
                ram_waddr = r_count[AW-1:0];
                ram_wdata = {COORD_BITS'(i_y_coord), COORD_BITS'(i_x_coord), i_depth_key};
                if (in_accept) begin
                    if (r_count < CNTW'(MAX_POINTS)) begin
                        ram_we  = 1'b1;
                        n_count = r_count + CNTW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_final_point) begin
                        n_gap   = n_count >> 1;
                        n_state = S_GAP;
                    end
                end
            end
            S_GAP: begin
                if (r_gap == '0) begin
                    n_i     = '0;
                    n_state = S_EMIT_RD;
                end else begin
                    n_i     = r_gap;
                    n_j     = '0;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (keys_in_order) begin
                    if (i_inc < r_count) begin
                        n_i     = i_inc;
                        n_j     = i_inc - r_gap;
                        n_state = S_READ;
                    end else begin
                        n_gap   = r_gap >> 1;
                        n_state = S_GAP;
                    end
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_j[AW-1:0];
                    ram_wdata = ram_rdata_b;
                    n_state   = S_SWAP;
                end
            end
            S_SWAP: begin
                ram_we    = 1'b1;
                ram_waddr = k_idx[AW-1:0];
                ram_wdata = r_lo;
                if (r_j >= r_gap) begin
                    n_j     = r_j - r_gap;
                    n_state = S_READ;
                end else if (i_inc < r_count) begin
                    n_i     = i_inc;
                    n_j     = i_inc - r_gap;
                    n_state = S_READ;
                end else begin
                    n_gap   = r_gap >> 1;
                    n_state = S_GAP;
                end
            end
            S_EMIT_RD: begin
                ram_raddr_a = r_i[AW-1:0];
                n_state     = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                ram_raddr_a = r_i[AW-1:0];
                n_out_valid = 1'b1;
                n_state     = S_EMIT_WAIT;
            end
            S_EMIT_WAIT: begin
                ram_raddr_a = r_i[AW-1:0];
                if (out_accept) begin
                    n_out_valid = 1'b0;
                    if (i_inc == r_count) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_i     = i_inc;
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_gap <= n_gap;
        r_i   <= n_i;
        r_j   <= n_j;
        if (r_state == S_CMP) begin
            r_lo <= ram_rdata_a;
        end
        if (r_state == S_EMIT_LD) begin
            r_out_key <= $signed(ram_rdata_a[KEY_BITS-1:0]);
            r_out_x   <= OUT_BITS'($signed(ram_rdata_a[KEY_BITS +: COORD_BITS]));
            r_out_y   <= OUT_BITS'($signed(ram_rdata_a[KEY_BITS + COORD_BITS +: COORD_BITS]));
            r_out_end <= (i_inc == r_count);
            r_out_ovf <= r_ovf;
        end
    end

    assign o_stall      = (r_state != S_LOAD);
    assign o_valid      = r_out_valid;
    assign o_sorted_key = r_out_key;
    assign o_sorted_x   = r_out_x;
    assign o_sorted_y   = r_out_y;
    assign o_end_of_set = r_out_end;
    assign o_overflowed = r_out_ovf;

endmodule
